// ===== rtl/lrsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsd_pkg: shared types, constants and helpers of the LZW/RLE stream decoder
// Transfer payloads, datapath micro-operations, status bundle, hash helpers.
// ----------------------------------------------------------------------------
package lrsd_pkg;

  localparam int unsigned DICT_ENTRIES_DEF = 4096;
  localparam int unsigned HASH_SLOTS       = 5003;
  localparam int unsigned INIT_CODES       = 260;
  localparam int unsigned ATOMIC_CODES     = 256;

  localparam logic [14:0] NO_PRED      = 15'h6fff;
  localparam logic [14:0] IMP_PRED     = 15'h7fff;
  localparam logic [11:0] CODE_END     = 12'h100;
  localparam logic [11:0] CODE_RESTART = 12'h101;
  localparam logic [11:0] CODE_FILL    = 12'h102;
  localparam logic [11:0] CODE_SPARE   = 12'h103;
  localparam logic [7:0]  RUN_MARK     = 8'h90;
  localparam logic [3:0]  WIDTH_MIN    = 4'd9;
  localparam logic [3:0]  WIDTH_MAX    = 4'd12;
  localparam logic [1:0]  FULL_LAST    = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        accepted;
    logic        finished;
    logic [15:0] running_sum;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_CLR_START,
    OP_CLEAR,
    OP_INIT_START,
    OP_INIT_LOAD,
    OP_INIT_NEXT,
    OP_INIT_TAIL,
    OP_HASH_SETUP,
    OP_PROBE_RD,
    OP_ENT_CHK,
    OP_ENT_FINAL,
    OP_SET_DONE,
    OP_PRE_LOAD,
    OP_PREV_LOAD,
    OP_CLR_EI,
    OP_REF_RD,
    OP_REF_WR,
    OP_WALK_RD,
    OP_WALK_USE,
    OP_RA_HCHK,
    OP_RA_DCHK,
    OP_TAIL,
    OP_PULL_REP,
    OP_PULL_RD,
    OP_PULL_USE,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic pull;        // presented item is a pull
    logic feed_code;   // presented feed is taken and completes a code
    logic code_skip;
    logic code_end;
    logic code_restart;
    logic code_new;    // code at or above next_entry
    logic full2;
    logic ent_room;    // next_entry below table size
    logic slot_used;
    logic probe_last;
    logic dict_ref;
    logic walk_more;
    logic entry_inhibit;
    logic clr_last;
    logic init_last;
    logic rep_nz;
    logic stack_nz;
    logic pull_hit;    // popped byte produces an output byte
  } stat_t;

  function automatic logic [12:0] hash_of(input logic [14:0] pred, input logic [7:0] suff);
    logic [11:0] h;
    h = ({1'b0, pred[14:4]} ^ {4'b0, suff}) | {pred[3:0], 8'b0};
    return {1'b0, h} + 13'd1;
  endfunction

  function automatic logic [12:0] hash_next(input logic [12:0] idx, input logic [12:0] step);
    logic [13:0] s;
    s = {1'b0, idx} + {1'b0, step};
    if (s >= 14'(HASH_SLOTS)) s = s - 14'(HASH_SLOTS);
    return s[12:0];
  endfunction

endpackage

// ===== rtl/lrsd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsd_datapath: registers, tables and arithmetic of the stream decoder
// Executes one micro-operation per cycle; holds dictionary, hash and stack.
// ----------------------------------------------------------------------------
module lrsd_datapath #(
  parameter int unsigned DICT_ENTRIES = lrsd_pkg::DICT_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  lrsd_pkg::op_t  op,
  input  lrsd_pkg::req_t cmd,
  output lrsd_pkg::stat_t stat,
  output lrsd_pkg::rsp_t res
);

  localparam int unsigned DW = $clog2(DICT_ENTRIES);
  localparam int unsigned SW = DW + 1;
  localparam logic [SW-1:0] WALK_LIMIT = SW'(DICT_ENTRIES - 1);
  localparam logic [12:0]   DICT_SIZE  = 13'(DICT_ENTRIES);

  // table index = value mod DICT_ENTRIES, quotient below eight
  function automatic logic [DW-1:0] tab_idx(input logic [11:0] v);
    logic [14:0] r;
    r = {3'b0, v};
    for (int k = 2; k >= 0; k--) begin
      if (r >= 15'(DICT_ENTRIES << k)) r = r - 15'(DICT_ENTRIES << k);
    end
    return r[DW-1:0];
  endfunction

  logic [20:0] dict_mem  [DICT_ENTRIES];
  logic [12:0] hash_mem  [lrsd_pkg::HASH_SLOTS];
  logic [7:0]  stack_mem [DICT_ENTRIES];

  logic [20:0] dict_rd;
  logic [12:0] hash_rd;
  logic [7:0]  stack_rd;

  // decoder state
  logic [SW-1:0] stack_depth;
  logic [23:0]   bit_buffer;
  logic [3:0]    bits_held;
  logic [3:0]    code_width;
  logic [12:0]   next_entry;
  logic [1:0]    full_stage;
  logic          entry_inhibit;
  logic [14:0]   previous_code;
  logic [7:0]    first_byte;
  logic          repeat_pending;
  logic [7:0]    last_sent_byte;
  logic [7:0]    repeat_left;
  logic [15:0]   byte_sum;
  logic          done_flag;
  logic [12:0]   clr_addr;
  logic          clr_dict;

  // work registers
  logic [11:0]   code;
  logic [11:0]   cur;
  logic [SW-1:0] depth;
  logic [12:0]   idx;
  logic [12:0]   step;
  logic [12:0]   probe_cnt;
  logic [14:0]   ent_pred;
  logic [7:0]    ent_suff;
  logic [8:0]    init_cnt;
  logic [DW-1:0] ra_ent;
  logic [7:0]    res_byte;
  logic          res_vld;
  logic          res_acc;

  logic [4:0]  nb;
  logic [23:0] feed_buf;
  logic        feed_avail;
  logic        feed_ok;
  logic [4:0]  sh;
  logic [11:0] code_mask;
  logic [11:0] feed_code;
  logic [23:0] buf_keep;
  logic [12:0] ne_inc;
  logic [12:0] width_lim;
  logic [20:0] ent_word;
  logic        ent_room;
  logic        walk_more;
  logic        pull_hit;

  logic          dict_we;
  logic [DW-1:0] dict_wa;
  logic [20:0]   dict_wd;
  logic [DW-1:0] dict_ra;
  logic          hash_we;
  logic [12:0]   hash_wa;
  logic [12:0]   hash_wd;
  logic          stack_we;
  logic [DW-1:0] stack_ra;

  assign nb         = {1'b0, bits_held} + 5'd8;
  assign feed_buf   = {bit_buffer[15:0], cmd.in_byte};
  assign feed_avail = nb >= {1'b0, code_width};
  assign feed_ok    = !done_flag && (stack_depth == '0) && (repeat_left == 8'd0);
  assign sh         = nb - {1'b0, code_width};
  assign code_mask  = 12'((13'd1 << code_width) - 13'd1);
  assign feed_code  = 12'(feed_buf >> sh) & code_mask;
  assign buf_keep   = feed_buf & ((24'd1 << sh[3:0]) - 24'd1);
  assign ne_inc     = next_entry + 13'd1;
  assign width_lim  = (13'd1 << code_width) - 13'd1;
  assign ent_word   = {ent_pred[13], ent_pred[11:0], ent_suff};
  assign ent_room   = next_entry < DICT_SIZE;
  assign walk_more  = (cur > 12'd255) && (depth < WALK_LIMIT);
  assign pull_hit   = repeat_pending ? (stack_rd == 8'd0) : (stack_rd != lrsd_pkg::RUN_MARK);

  // memory ports
  always_comb begin
    dict_we  = 1'b0;
    dict_wa  = next_entry[DW-1:0];
    dict_wd  = ent_word;
    hash_we  = 1'b0;
    hash_wa  = idx;
    hash_wd  = {1'b1, next_entry[11:0]};
    stack_we = 1'b0;
    case (op)
      lrsd_pkg::OP_CLEAR: begin
        dict_we = clr_dict && (clr_addr < DICT_SIZE);
        dict_wa = clr_addr[DW-1:0];
        dict_wd = '0;
        hash_we = 1'b1;
        hash_wa = clr_addr;
        hash_wd = '0;
      end
      lrsd_pkg::OP_ENT_CHK:   hash_we = !hash_rd[12];
      lrsd_pkg::OP_ENT_FINAL: dict_we = ent_room;
      lrsd_pkg::OP_REF_WR: begin
        dict_we = 1'b1;
        dict_wa = tab_idx(code);
        dict_wd = dict_rd | 21'h100000;
      end
      lrsd_pkg::OP_RA_DCHK: begin
        dict_we = !dict_rd[20];
        dict_wa = ra_ent;
      end
      lrsd_pkg::OP_WALK_USE:  stack_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    case (op)
      lrsd_pkg::OP_REF_RD:  dict_ra = tab_idx(code);
      lrsd_pkg::OP_RA_HCHK: dict_ra = tab_idx(hash_rd[11:0]);
      default:              dict_ra = tab_idx(cur);
    endcase
  end

  assign stack_ra = DW'(stack_depth - SW'(1));

  always_ff @(posedge clk) begin
    if (dict_we) dict_mem[dict_wa] <= dict_wd;
    dict_rd <= dict_mem[dict_ra];
  end

  always_ff @(posedge clk) begin
    if (hash_we) hash_mem[hash_wa] <= hash_wd;
    hash_rd <= hash_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[depth[DW-1:0]] <= dict_rd[7:0];
    stack_rd <= stack_mem[stack_ra];
  end

  // micro-operations
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_depth    <= '0;
      bit_buffer     <= '0;
      bits_held      <= '0;
      code_width     <= lrsd_pkg::WIDTH_MIN;
      next_entry     <= 13'(lrsd_pkg::INIT_CODES);
      full_stage     <= '0;
      entry_inhibit  <= 1'b1;
      previous_code  <= lrsd_pkg::NO_PRED;
      first_byte     <= '0;
      repeat_pending <= 1'b0;
      last_sent_byte <= '0;
      repeat_left    <= '0;
      byte_sum       <= '0;
      done_flag      <= 1'b0;
      clr_addr       <= '0;
      clr_dict       <= 1'b1;
    end else begin
      unique case (op)
        lrsd_pkg::OP_ACCEPT: begin
          res_byte <= '0;
          res_vld  <= 1'b0;
          res_acc  <= !cmd.mode && feed_ok;
          if (!cmd.mode && feed_ok) begin
            if (feed_avail) begin
              code       <= feed_code;
              bits_held  <= sh[3:0];
              bit_buffer <= buf_keep;
            end else begin
              bits_held  <= nb[3:0];
              bit_buffer <= feed_buf;
            end
          end
        end
        lrsd_pkg::OP_CLR_START: clr_addr <= '0;
        lrsd_pkg::OP_CLEAR: begin
          clr_addr <= clr_addr + 13'd1;
          if (stat.clr_last) clr_dict <= 1'b0;
        end
        lrsd_pkg::OP_INIT_START: begin
          next_entry <= '0;
          full_stage <= '0;
          code_width <= lrsd_pkg::WIDTH_MIN;
          init_cnt   <= '0;
        end
        lrsd_pkg::OP_INIT_LOAD: begin
          if (init_cnt < 9'(lrsd_pkg::ATOMIC_CODES)) begin
            ent_pred <= lrsd_pkg::NO_PRED;
            ent_suff <= init_cnt[7:0];
          end else begin
            ent_pred <= lrsd_pkg::IMP_PRED;
            ent_suff <= '0;
          end
        end
        lrsd_pkg::OP_INIT_NEXT: init_cnt <= init_cnt + 9'd1;
        lrsd_pkg::OP_INIT_TAIL: begin
          previous_code <= lrsd_pkg::NO_PRED;
          entry_inhibit <= 1'b1;
        end
        lrsd_pkg::OP_HASH_SETUP: begin
          idx       <= lrsd_pkg::hash_of(ent_pred, ent_suff);
          step      <= lrsd_pkg::hash_of(ent_pred, ent_suff);
          probe_cnt <= '0;
        end
        lrsd_pkg::OP_ENT_CHK: begin
          if (hash_rd[12]) begin
            idx       <= lrsd_pkg::hash_next(idx, step);
            probe_cnt <= probe_cnt + 13'd1;
          end
        end
        lrsd_pkg::OP_ENT_FINAL: begin
          next_entry <= ne_inc;
          if (ne_inc >= width_lim) begin
            if (code_width < lrsd_pkg::WIDTH_MAX) code_width <= code_width + 4'd1;
            else if (full_stage < lrsd_pkg::FULL_LAST) full_stage <= full_stage + 2'd1;
          end
        end
        lrsd_pkg::OP_SET_DONE: done_flag <= 1'b1;
        lrsd_pkg::OP_PRE_LOAD: begin
          entry_inhibit <= 1'b1;
          ent_pred      <= previous_code;
          ent_suff      <= first_byte;
        end
        lrsd_pkg::OP_PREV_LOAD: begin
          ent_pred <= previous_code;
          ent_suff <= first_byte;
        end
        lrsd_pkg::OP_CLR_EI: entry_inhibit <= 1'b0;
        lrsd_pkg::OP_REF_WR: begin
          cur   <= code;
          depth <= '0;
        end
        lrsd_pkg::OP_WALK_USE: begin
          if (walk_more) begin
            depth <= depth + SW'(1);
            cur   <= dict_rd[19:8];
          end else begin
            first_byte  <= dict_rd[7:0];
            stack_depth <= depth + SW'(1);
          end
        end
        lrsd_pkg::OP_RA_HCHK: ra_ent <= tab_idx(hash_rd[11:0]);
        lrsd_pkg::OP_RA_DCHK: begin
          if (dict_rd[20]) begin
            idx       <= lrsd_pkg::hash_next(idx, step);
            probe_cnt <= probe_cnt + 13'd1;
          end
        end
        lrsd_pkg::OP_TAIL: previous_code <= {3'b0, code};
        lrsd_pkg::OP_PULL_REP: begin
          repeat_left <= repeat_left - 8'd1;
          res_byte    <= last_sent_byte;
          res_vld     <= 1'b1;
          byte_sum    <= byte_sum + {8'b0, last_sent_byte};
        end
        lrsd_pkg::OP_PULL_RD: stack_depth <= stack_depth - SW'(1);
        lrsd_pkg::OP_PULL_USE: begin
          if (repeat_pending) begin
            repeat_pending <= 1'b0;
            if (stack_rd != 8'd0) begin
              repeat_left <= stack_rd - 8'd1;
            end else begin
              res_byte <= lrsd_pkg::RUN_MARK;
              res_vld  <= 1'b1;
              byte_sum <= byte_sum + {8'b0, lrsd_pkg::RUN_MARK};
            end
          end else if (stack_rd == lrsd_pkg::RUN_MARK) begin
            repeat_pending <= 1'b1;
          end else begin
            last_sent_byte <= stack_rd;
            res_byte       <= stack_rd;
            res_vld        <= 1'b1;
            byte_sum       <= byte_sum + {8'b0, stack_rd};
          end
        end
        lrsd_pkg::OP_EMIT: begin
          res.out_byte    <= res_byte;
          res.out_valid   <= res_vld;
          res.accepted    <= res_acc;
          res.finished    <= done_flag;
          res.running_sum <= byte_sum;
        end
        default: ;
      endcase
    end
  end

  // status to the controller
  always_comb begin
    stat.pull          = cmd.mode;
    stat.feed_code     = !cmd.mode && feed_ok && feed_avail;
    stat.code_skip     = (code == lrsd_pkg::CODE_FILL) || (code == lrsd_pkg::CODE_SPARE);
    stat.code_end      = code == lrsd_pkg::CODE_END;
    stat.code_restart  = code == lrsd_pkg::CODE_RESTART;
    stat.code_new      = {1'b0, code} >= next_entry;
    stat.full2         = full_stage == lrsd_pkg::FULL_LAST;
    stat.ent_room      = ent_room;
    stat.slot_used     = hash_rd[12];
    stat.probe_last    = probe_cnt == 13'(lrsd_pkg::HASH_SLOTS - 1);
    stat.dict_ref      = dict_rd[20];
    stat.walk_more     = walk_more;
    stat.entry_inhibit = entry_inhibit;
    stat.clr_last      = clr_addr == 13'(lrsd_pkg::HASH_SLOTS - 1);
    stat.init_last     = init_cnt == 9'(lrsd_pkg::INIT_CODES - 1);
    stat.rep_nz        = repeat_left != 8'd0;
    stat.stack_nz      = stack_depth != '0;
    stat.pull_hit      = pull_hit;
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    op == lrsd_pkg::OP_PULL_RD |-> stack_depth != '0)
    else $error("stack pop with empty stack");

  a_entry_count: assert property (@(posedge clk) disable iff (rst)
    op == lrsd_pkg::OP_ENT_FINAL |=> next_entry == $past(next_entry) + 13'd1)
    else $error("next_entry did not advance by one");

  a_walk_push: assert property (@(posedge clk) disable iff (rst)
    op == lrsd_pkg::OP_WALK_USE && walk_more |=> depth == $past(depth) + SW'(1))
    else $error("walk depth did not advance");
`endif

endmodule

// ===== rtl/lrsd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsd_ctrl: sequencing state machine of the stream decoder
// Issues datapath micro-operations and owns both transfer handshakes.
// ----------------------------------------------------------------------------
module lrsd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  output logic            res_valid,
  input  logic            res_ready,
  input  lrsd_pkg::stat_t stat,
  output lrsd_pkg::op_t   op
);

  typedef enum logic [4:0] {
    S_CLEAR, S_INIT_START, S_INIT_LOAD, S_INIT_NEXT, S_INIT_TAIL,
    S_IDLE, S_DISPATCH, S_RST_START, S_SET_DONE, S_PRE,
    S_ENT_SETUP, S_ENT_RD, S_ENT_CHK, S_ENT_FINAL,
    S_REF_RD, S_REF_WR, S_WALK_RD, S_WALK_USE,
    S_POST, S_POST_LOAD, S_CLR_EI,
    S_RA_LOAD, S_RA_SETUP, S_RA_RD, S_RA_HCHK, S_RA_DCHK,
    S_TAIL, S_PULL, S_PULL_USE, S_FIN
  } state_t;

  typedef enum logic [1:0] {RET_INIT, RET_PRE, RET_POST} ret_t;

  state_t state;
  ret_t   ret;
  logic   boot;
  logic   fs2;
  logic   emit;

  assign cmd_ready = state == S_IDLE;
  assign emit      = (state == S_FIN) && (!res_valid || res_ready);

  always_comb begin
    unique case (state)
      S_CLEAR:      op = lrsd_pkg::OP_CLEAR;
      S_INIT_START: op = lrsd_pkg::OP_INIT_START;
      S_INIT_LOAD:  op = lrsd_pkg::OP_INIT_LOAD;
      S_INIT_NEXT:  op = lrsd_pkg::OP_INIT_NEXT;
      S_INIT_TAIL:  op = lrsd_pkg::OP_INIT_TAIL;
      S_IDLE:       op = cmd_valid ? lrsd_pkg::OP_ACCEPT : lrsd_pkg::OP_IDLE;
      S_RST_START:  op = lrsd_pkg::OP_CLR_START;
      S_SET_DONE:   op = lrsd_pkg::OP_SET_DONE;
      S_PRE:        op = lrsd_pkg::OP_PRE_LOAD;
      S_ENT_SETUP:  op = lrsd_pkg::OP_HASH_SETUP;
      S_ENT_RD:     op = lrsd_pkg::OP_PROBE_RD;
      S_ENT_CHK:    op = lrsd_pkg::OP_ENT_CHK;
      S_ENT_FINAL:  op = lrsd_pkg::OP_ENT_FINAL;
      S_REF_RD:     op = lrsd_pkg::OP_REF_RD;
      S_REF_WR:     op = lrsd_pkg::OP_REF_WR;
      S_WALK_RD:    op = lrsd_pkg::OP_WALK_RD;
      S_WALK_USE:   op = lrsd_pkg::OP_WALK_USE;
      S_POST_LOAD:  op = lrsd_pkg::OP_PREV_LOAD;
      S_CLR_EI:     op = lrsd_pkg::OP_CLR_EI;
      S_RA_LOAD:    op = lrsd_pkg::OP_PREV_LOAD;
      S_RA_SETUP:   op = lrsd_pkg::OP_HASH_SETUP;
      S_RA_RD:      op = lrsd_pkg::OP_PROBE_RD;
      S_RA_HCHK:    op = lrsd_pkg::OP_RA_HCHK;
      S_RA_DCHK:    op = lrsd_pkg::OP_RA_DCHK;
      S_TAIL:       op = lrsd_pkg::OP_TAIL;
      S_PULL: begin
        if (stat.rep_nz)        op = lrsd_pkg::OP_PULL_REP;
        else if (stat.stack_nz) op = lrsd_pkg::OP_PULL_RD;
        else                    op = lrsd_pkg::OP_IDLE;
      end
      S_PULL_USE:   op = lrsd_pkg::OP_PULL_USE;
      S_FIN:        op = emit ? lrsd_pkg::OP_EMIT : lrsd_pkg::OP_IDLE;
      default:      op = lrsd_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ret       <= RET_INIT;
      boot      <= 1'b1;
      fs2       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && !emit) res_valid <= 1'b0;
      unique case (state)
        S_CLEAR:      if (stat.clr_last) state <= S_INIT_START;
        S_INIT_START: state <= S_INIT_LOAD;
        S_INIT_LOAD: begin
          ret   <= RET_INIT;
          state <= S_ENT_SETUP;
        end
        S_INIT_NEXT:  state <= stat.init_last ? S_INIT_TAIL : S_INIT_LOAD;
        S_INIT_TAIL: begin
          boot  <= 1'b0;
          state <= boot ? S_IDLE : S_FIN;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            if (stat.pull)           state <= S_PULL;
            else if (stat.feed_code) state <= S_DISPATCH;
            else                     state <= S_FIN;
          end
        end
        S_DISPATCH: begin
          fs2 <= stat.full2;
          if (stat.code_skip)         state <= S_FIN;
          else if (stat.code_end)     state <= S_SET_DONE;
          else if (stat.code_restart) state <= S_RST_START;
          else if (stat.code_new)     state <= S_PRE;
          else                        state <= S_REF_RD;
        end
        S_RST_START:  state <= S_CLEAR;
        S_SET_DONE:   state <= S_FIN;
        S_PRE: begin
          ret   <= RET_PRE;
          state <= S_ENT_SETUP;
        end
        S_ENT_SETUP:  state <= stat.ent_room ? S_ENT_RD : S_ENT_FINAL;
        S_ENT_RD:     state <= S_ENT_CHK;
        S_ENT_CHK: begin
          if (!stat.slot_used || stat.probe_last) state <= S_ENT_FINAL;
          else                                    state <= S_ENT_RD;
        end
        S_ENT_FINAL: begin
          unique case (ret)
            RET_INIT: state <= S_INIT_NEXT;
            RET_PRE:  state <= S_REF_RD;
            RET_POST: state <= S_TAIL;
            default:  state <= S_TAIL;
          endcase
        end
        S_REF_RD:     state <= S_REF_WR;
        S_REF_WR:     state <= S_WALK_RD;
        S_WALK_RD:    state <= S_WALK_USE;
        S_WALK_USE:   state <= stat.walk_more ? S_WALK_RD : S_POST;
        S_POST: begin
          if (fs2)                     state <= S_RA_LOAD;
          else if (!stat.entry_inhibit) state <= S_POST_LOAD;
          else                         state <= S_CLR_EI;
        end
        S_POST_LOAD: begin
          ret   <= RET_POST;
          state <= S_ENT_SETUP;
        end
        S_CLR_EI:     state <= S_TAIL;
        S_RA_LOAD:    state <= S_RA_SETUP;
        S_RA_SETUP:   state <= S_RA_RD;
        S_RA_RD:      state <= S_RA_HCHK;
        S_RA_HCHK:    state <= stat.slot_used ? S_RA_DCHK : S_TAIL;
        S_RA_DCHK: begin
          if (!stat.dict_ref || stat.probe_last) state <= S_TAIL;
          else                                   state <= S_RA_RD;
        end
        S_TAIL:       state <= S_FIN;
        S_PULL: begin
          if (stat.rep_nz)        state <= S_FIN;
          else if (stat.stack_nz) state <= S_PULL_USE;
          else                    state <= S_FIN;
        end
        S_PULL_USE:   state <= stat.pull_hit ? S_FIN : S_PULL;
        S_FIN: begin
          if (emit) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default:      state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    emit |=> res_valid && state == S_IDLE)
    else $error("result not presented after emit");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> state != S_IDLE)
    else $error("accepted transfer left controller idle");

  a_clear_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR && !stat.clr_last |=> state == S_CLEAR)
    else $error("clearing sweep cut short");
`endif

endmodule

// ===== rtl/lzw_rle_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_rle_stream_decoder: LZW (9..12 bit) decoder with 0x90 run expansion
// Feeds compressed bytes, pulls decoded bytes, keeps a 16-bit byte sum.
// ----------------------------------------------------------------------------
// A feed that completes no code returns its result without touching the tables;
//   a code walks its string through the dictionary byte by byte and makes
//   entry hash probes and reassignment probes, one typically.
// One item at a time: a pull serves a pending run first, else pops the stack,
//   popping again past each run marker or count consumed.
//   The single-port dictionary and hash reads set the pace.
// Reset (and a restart code): a clearing pass over the 5003-slot hash table,
//   then entering the 260 initial codes; cmd_ready stays low.
// ----------------------------------------------------------------------------
module lzw_rle_stream_decoder #(
  parameter int unsigned DICT_ENTRIES = lrsd_pkg::DICT_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  lrsd_pkg::req_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output lrsd_pkg::rsp_t res
);

  // Controller sequences micro-operations; the datapath holds every table.
  // Result payload sits in a register in the datapath, so a new transfer is
  // taken while the previous result still waits on res_ready.
  lrsd_pkg::op_t   op;
  lrsd_pkg::stat_t stat;

  lrsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .stat      (stat),
    .op        (op)
  );

  lrsd_datapath #(
    .DICT_ENTRIES (DICT_ENTRIES)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .cmd  (cmd),
    .stat (stat),
    .res  (res)
  );

endmodule
